// ===== rtl/swrm_pkg.sv =====
// Shared widths and constants for the sliding-window rate meter.
// No dependencies; used by every module of the block.
`default_nettype none

package swrm_pkg;

	localparam int BYTES_W    = 31;
	localparam int BUCKET_W   = 32;
	localparam int TOTAL_W    = 40;
	localparam int RATE_W     = 31;
	localparam int TDATA_W    = 32;

	// reciprocal divide; a divisor up to 64 adds 6 bits of dividend below the clip
	localparam int NUM_W      = RATE_W + 6;
	localparam int DIV_SHIFT  = NUM_W + 6;
	localparam int RECIP_W    = DIV_SHIFT + 1;
	localparam int LO_W       = 19;
	localparam int HI_W       = NUM_W - LO_W;
	localparam int R_LO_W     = 22;
	localparam int R_HI_W     = RECIP_W - R_LO_W;
	localparam int PP_W       = LO_W + R_LO_W;
	localparam int PROD_W     = DIV_SHIFT + RATE_W;

	localparam logic [RATE_W-1:0] RATE_MAX = {RATE_W{1'b1}};

endpackage

`default_nettype wire

// ===== rtl/swrm_window.sv =====
// Bucket ring, ring position, open bucket and running window total.
// Depends on swrm_pkg.
`default_nettype none

module swrm_window #(
	parameter int NUM_BUCKETS = 16
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           acc,
	input  wire logic                           tick,
	input  wire logic [swrm_pkg::BYTES_W-1:0]   bytes,
	output logic      [swrm_pkg::TOTAL_W-1:0]   total_nxt
);

	localparam int PW = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
	localparam logic [PW-1:0] POS_LAST = PW'(NUM_BUCKETS - 1);

	logic [swrm_pkg::BUCKET_W-1:0] ring_mem [NUM_BUCKETS];
	logic [NUM_BUCKETS-1:0]        bvld_q;
	logic [swrm_pkg::BUCKET_W-1:0] rd_q;
	logic                          rd_vld_q;
	logic [PW-1:0]                 pos_q;
	logic [PW-1:0]                 pos_nxt;
	logic [swrm_pkg::TOTAL_W-1:0]  tot_q;
	logic [swrm_pkg::BUCKET_W-1:0] open_q;
	logic [swrm_pkg::BUCKET_W-1:0] old_bkt;
	logic [swrm_pkg::BUCKET_W-1:0] open_base;
	logic [swrm_pkg::BUCKET_W:0]   open_sum;
	logic                          close;

	assign close   = acc & tick;
	assign pos_nxt = !close ? pos_q : ((pos_q == POS_LAST) ? '0 : pos_q + 1'b1);
	assign old_bkt = rd_vld_q ? rd_q : '0;

	assign total_nxt = close
		? (tot_q - {{(swrm_pkg::TOTAL_W-swrm_pkg::BUCKET_W){1'b0}}, old_bkt}
			+ {{(swrm_pkg::TOTAL_W-swrm_pkg::BUCKET_W){1'b0}}, open_q})
		: tot_q;

	assign open_base = tick ? '0 : open_q;
	assign open_sum  = {1'b0, open_base}
		+ {{(swrm_pkg::BUCKET_W+1-swrm_pkg::BYTES_W){1'b0}}, bytes};

	// read port prefetches the bucket at the next position
	always_ff @(posedge clk) begin
		if (close) begin
			ring_mem[pos_q] <= open_q;
		end
		rd_q <= ring_mem[pos_nxt];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bvld_q   <= '0;
			rd_vld_q <= 1'b0;
			pos_q    <= '0;
			tot_q    <= '0;
			open_q   <= '0;
		end else begin
			if (close) begin
				bvld_q[pos_q] <= 1'b1;
			end
			rd_vld_q <= bvld_q[pos_nxt];
			pos_q    <= pos_nxt;
			if (acc) begin
				tot_q  <= total_nxt;
				open_q <= open_sum[swrm_pkg::BUCKET_W] ? '1
					: open_sum[swrm_pkg::BUCKET_W-1:0];
			end
		end
	end

	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, pos_q} <= {1'b0, POS_LAST})
		else $error("ring position out of range");

	a_pos_adv: assert property (@(posedge clk) disable iff (!arst_n)
		close |=> pos_q != $past(pos_q))
		else $error("ring position did not advance on tick");

	a_idle_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!acc |=> $stable(tot_q) && $stable(open_q) && $stable(pos_q))
		else $error("window state changed without a transfer");

endmodule

`default_nettype wire

// ===== rtl/swrm_div_stage.sv =====
// Constant divider for the window total: reciprocal multiply over two registered stages.
// Depends on swrm_pkg; DIVISOR must lie in 1..64, which the block itself does not enforce.
`default_nettype none

module swrm_div_stage #(
	parameter int DIVISOR = 1
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 in_valid,
	output logic                                      in_ready,
	input  wire logic [swrm_pkg::TOTAL_W-1:0]         total,
	output logic                                      out_valid,
	input  wire logic                                 out_ready,
	output logic      [swrm_pkg::RATE_W-1:0]          quot,
	output logic                                      sat
);

	localparam int PP_W   = swrm_pkg::PP_W;
	localparam int PROD_W = swrm_pkg::PROD_W;
	localparam logic [63:0] RECIP_64 =
		((64'd1 << swrm_pkg::DIV_SHIFT) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
	localparam logic [63:0] LIMIT_64 = 64'(DIVISOR) << swrm_pkg::RATE_W;
	localparam logic [swrm_pkg::R_LO_W-1:0] R_LO = RECIP_64[swrm_pkg::R_LO_W-1:0];
	localparam logic [swrm_pkg::R_HI_W-1:0] R_HI =
		RECIP_64[swrm_pkg::RECIP_W-1:swrm_pkg::R_LO_W];
	localparam logic [swrm_pkg::TOTAL_W-1:0] SAT_LIMIT = LIMIT_64[swrm_pkg::TOTAL_W-1:0];

	logic                         vld_s1;
	logic [swrm_pkg::TOTAL_W-1:0] tot_s1;
	logic                         rdy_s2;
	logic                         vld_s2;
	logic                         sat_s2;
	logic [PP_W-1:0]              pp_ll_s2;
	logic [PP_W-1:0]              pp_lh_s2;
	logic [PP_W-1:0]              pp_hl_s2;
	logic [PP_W-1:0]              pp_hh_s2;
	logic [swrm_pkg::LO_W-1:0]    n_lo;
	logic [swrm_pkg::HI_W-1:0]    n_hi;
	logic [PROD_W-1:0]            prod;

	// below the clip limit the total fits NUM_W bits
	assign n_lo = tot_s1[swrm_pkg::LO_W-1:0];
	assign n_hi = tot_s1[swrm_pkg::NUM_W-1:swrm_pkg::LO_W];

	assign rdy_s2    = !vld_s2 | out_ready;
	assign in_ready  = !vld_s1 | rdy_s2;
	assign out_valid = vld_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (in_ready) begin
				vld_s1 <= in_valid;
			end
			if (rdy_s2) begin
				vld_s2 <= vld_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			tot_s1 <= total;
		end
		if (vld_s1 && rdy_s2) begin
			sat_s2   <= tot_s1 >= SAT_LIMIT;
			pp_ll_s2 <= PP_W'(n_lo) * PP_W'(R_LO);
			pp_lh_s2 <= PP_W'(n_lo) * PP_W'(R_HI);
			pp_hl_s2 <= PP_W'(n_hi) * PP_W'(R_LO);
			pp_hh_s2 <= PP_W'(n_hi) * PP_W'(R_HI);
		end
	end

	assign prod = PROD_W'(pp_ll_s2)
		+ (PROD_W'(pp_lh_s2) << swrm_pkg::R_LO_W)
		+ (PROD_W'(pp_hl_s2) << swrm_pkg::LO_W)
		+ (PROD_W'(pp_hh_s2) << (swrm_pkg::LO_W + swrm_pkg::R_LO_W));
	assign quot = prod[PROD_W-1:swrm_pkg::DIV_SHIFT];
	assign sat  = sat_s2;

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 && !rdy_s2 |=> vld_s1 && $stable(tot_s1))
		else $error("stage 1 item not held while stalled");

	a_s2_hold: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s2 && !out_ready |=> vld_s2 && $stable(sat_s2) && $stable(pp_hh_s2)
			&& $stable(pp_ll_s2))
		else $error("stage 2 item not held while stalled");

endmodule

`default_nettype wire

// ===== rtl/sliding_window_rate_meter_top.sv =====
// Sliding-window rate meter: top level with window state, constant divider, output register.
// Depends on swrm_pkg, swrm_window, swrm_div_stage.
//
// Usage:
//   Slave stream carries one transfer per event: s_axis_tuser[0] is the tick
//   (a bucket period ended before these bytes), s_axis_tdata[30:0] the byte
//   count. Master stream returns one transfer per input transfer, in order:
//   m_axis_tdata[30:0] is the closed-bucket window total divided by
//   WINDOW_SECONDS (1..64), clipped to 2^31-1; m_axis_tuser[0] flags the clip.
//   Bytes in the open bucket count only after the next tick closes it.
//   Throughput: one transfer per cycle while m_axis_tready stays high.
//   Window state updates at acceptance; the new total is registered, split
//   into partial products of a reciprocal multiply, then summed, clipped and
//   held in the output register. Three registers hold items in flight; each
//   holds while the next is full and bubbles collapse, so input keeps flowing
//   while results wait until all three are full, then s_axis_tready drops.
//   Reset (arst_n low) zeroes the ring (per-entry valid bits), the position,
//   the open bucket and the window total, and empties the pipeline.
`default_nettype none

module sliding_window_rate_meter_top #(
	parameter int NUM_BUCKETS    = 16,
	parameter int WINDOW_SECONDS = 1
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           s_axis_tvalid,
	output logic                                s_axis_tready,
	input  wire logic [swrm_pkg::TDATA_W-1:0]   s_axis_tdata,  // [30:0] bytes
	input  wire logic [0:0]                     s_axis_tuser,  // [0] tick
	output logic                                m_axis_tvalid,
	input  wire logic                           m_axis_tready,
	output logic      [swrm_pkg::TDATA_W-1:0]   m_axis_tdata,  // [30:0] rate
	output logic      [0:0]                     m_axis_tuser   // [0] saturated
);

	logic                         acc;
	logic [swrm_pkg::TOTAL_W-1:0] total_nxt;
	logic                         dv_vld;
	logic [swrm_pkg::RATE_W-1:0]  dv_quot;
	logic                         dv_sat;
	logic                         out_en;
	logic                         m_vld_q;
	logic [swrm_pkg::RATE_W-1:0]  rate_q;
	logic                         sat_q;

	assign acc = s_axis_tvalid & s_axis_tready;

	swrm_window #(
		.NUM_BUCKETS(NUM_BUCKETS)
	) u_window (
		.clk      (clk),
		.arst_n   (arst_n),
		.acc      (acc),
		.tick     (s_axis_tuser[0]),
		.bytes    (s_axis_tdata[swrm_pkg::BYTES_W-1:0]),
		.total_nxt(total_nxt)
	);

	swrm_div_stage #(
		.DIVISOR(WINDOW_SECONDS)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.total    (total_nxt),
		.out_valid(dv_vld),
		.out_ready(out_en),
		.quot     (dv_quot),
		.sat      (dv_sat)
	);

	assign out_en = !m_vld_q | m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_vld_q <= 1'b0;
		end else if (out_en) begin
			m_vld_q <= dv_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (out_en && dv_vld) begin
			rate_q <= dv_sat ? swrm_pkg::RATE_MAX : dv_quot;
			sat_q  <= dv_sat;
		end
	end

	assign m_axis_tvalid   = m_vld_q;
	assign m_axis_tdata    = {{(swrm_pkg::TDATA_W-swrm_pkg::RATE_W){1'b0}}, rate_q};
	assign m_axis_tuser[0] = sat_q;

	a_sat_max: assert property (@(posedge clk) disable iff (!arst_n)
		m_vld_q && sat_q |-> rate_q == swrm_pkg::RATE_MAX)
		else $error("saturated result without maximum rate");

endmodule

`default_nettype wire

// ===== tb/sliding_window_rate_meter_top_tb.sv =====
// Self-checking testbench for sliding_window_rate_meter_top: directed and random streams of
// tick/byte transfers, each result checked against a cycle-free model of the bucket window.
// Depends on swrm_pkg and the sliding_window_rate_meter_top RTL.
`default_nettype none

module sliding_window_rate_meter_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int BYTES_W        = swrm_pkg::BYTES_W;
	localparam int BUCKET_W       = swrm_pkg::BUCKET_W;
	localparam int TOTAL_W        = swrm_pkg::TOTAL_W;
	localparam int RATE_W         = swrm_pkg::RATE_W;
	localparam int TDATA_W        = swrm_pkg::TDATA_W;
	localparam logic [RATE_W-1:0] RATE_MAX = swrm_pkg::RATE_MAX;

	localparam int NUM_BUCKETS    = 16;
	localparam int WINDOW_SECONDS = 1;
	localparam int PIPE_LATENCY   = 3;
	localparam int RANDOM_ITEMS   = 1200;
	localparam int MAX_PRINTS     = 100;

	typedef struct packed {
		logic [RATE_W-1:0] rate;
		logic              saturated;
	} rate_result_t;

	typedef enum int {RX_ALWAYS, RX_RANDOM, RX_PATTERN, RX_SPARSE} rx_mode_t;
	typedef enum int {LOAD_HEAVY, LOAD_LIGHT, LOAD_AGING, LOAD_NOISE} load_profile_t;

	logic                clk;
	logic                arst_n;
	logic                s_axis_tvalid;
	logic                s_axis_tready;
	logic [TDATA_W-1:0]  s_axis_tdata;   // [30:0] bytes, [31] zero
	logic [0:0]          s_axis_tuser;   // [0] tick
	logic                m_axis_tvalid;
	logic                m_axis_tready;
	logic [TDATA_W-1:0]  m_axis_tdata;   // [30:0] rate
	logic [0:0]          m_axis_tuser;   // [0] saturated

	// window model
	logic [BUCKET_W-1:0] bucket_ring_m [NUM_BUCKETS];
	int                  ring_pos_m;
	logic [TOTAL_W-1:0]  window_sum_m;
	logic [BUCKET_W-1:0] open_sum_m;

	rate_result_t        expected_rates [$];
	int                  mismatches;
	int                  items_sent;

	bit                  sender_bursty;
	int                  burst_left;
	rx_mode_t            rx_mode;
	int                  stall_req;
	int                  stall_left;
	int                  pattern_phase;

	sliding_window_rate_meter_top #(
		.NUM_BUCKETS   (NUM_BUCKETS),
		.WINDOW_SECONDS(WINDOW_SECONDS)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("tb: failure");
		$finish;
	end

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		if (mismatches < MAX_PRINTS)
			$display("mismatch at %0t: %s got 0x%0h expected 0x%0h", $realtime, what, got, want);
		mismatches++;
	endtask

	task automatic clear_window_model();
		for (int i = 0; i < NUM_BUCKETS; i++)
			bucket_ring_m[i] = '0;
		ring_pos_m   = 0;
		window_sum_m = '0;
		open_sum_m   = '0;
	endtask

	task automatic predict_rate(input logic tick, input logic [BYTES_W-1:0] nbytes);
		logic [BUCKET_W:0]  sum;
		logic [TOTAL_W-1:0] quotient;
		rate_result_t       res;
		if (tick) begin
			window_sum_m = window_sum_m - TOTAL_W'(bucket_ring_m[ring_pos_m])
				+ TOTAL_W'(open_sum_m);
			bucket_ring_m[ring_pos_m] = open_sum_m;
			ring_pos_m = (ring_pos_m == NUM_BUCKETS - 1) ? 0 : ring_pos_m + 1;
			open_sum_m = '0;
		end
		sum = {1'b0, open_sum_m} + (BUCKET_W + 1)'(nbytes);
		open_sum_m = sum[BUCKET_W] ? {BUCKET_W{1'b1}} : sum[BUCKET_W-1:0];
		quotient = window_sum_m / TOTAL_W'(WINDOW_SECONDS);
		if (quotient > TOTAL_W'(RATE_MAX)) begin
			res.rate      = RATE_MAX;
			res.saturated = 1'b1;
		end else begin
			res.rate      = quotient[RATE_W-1:0];
			res.saturated = 1'b0;
		end
		expected_rates.push_back(res);
	endtask

	task automatic send_item(input logic tick, input logic [BYTES_W-1:0] nbytes);
		@(negedge clk);
		if (sender_bursty) begin
			if (burst_left == 0) begin
				s_axis_tvalid <= 1'b0;
				repeat ($urandom_range(1, 6)) @(negedge clk);
				burst_left = $urandom_range(1, 24);
			end
			burst_left--;
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {{(TDATA_W - BYTES_W){1'b0}}, nbytes};
		s_axis_tuser  <= tick;
		do
			@(posedge clk);
		while (!s_axis_tready);
		predict_rate(tick, nbytes);
		items_sent++;
	endtask

	task automatic sender_rest();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
	endtask

	always @(negedge clk) begin
		if (stall_req > 0) begin
			stall_left = stall_req;
			stall_req  = 0;
		end
		if (stall_left > 0) begin
			stall_left--;
			m_axis_tready <= 1'b0;
		end else begin
			case (rx_mode)
				RX_ALWAYS:  m_axis_tready <= 1'b1;
				RX_RANDOM:  m_axis_tready <= 1'($urandom_range(0, 1));
				RX_PATTERN: m_axis_tready <= (pattern_phase < 3);
				RX_SPARSE:  m_axis_tready <= ($urandom_range(0, 7) == 0);
				default:    m_axis_tready <= 1'b1;
			endcase
		end
		pattern_phase = (pattern_phase + 1) % 7;
	end

	always @(posedge clk) begin : check_result
		rate_result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (expected_rates.size() == 0) begin
				report_mismatch("result with no transfer pending", 64'(m_axis_tdata), '0);
			end else begin
				want = expected_rates.pop_front();
				if (m_axis_tdata[RATE_W-1:0] !== want.rate)
					report_mismatch("rate", 64'(m_axis_tdata[RATE_W-1:0]), 64'(want.rate));
				if (m_axis_tuser[0] !== want.saturated)
					report_mismatch("saturated", 64'(m_axis_tuser[0]), 64'(want.saturated));
			end
		end
	end

	// empty window answers zero, with and without a tick
	task automatic test_empty_window();
		send_item(1'b0, '0);
		send_item(1'b1, '0);
		sender_rest();
	endtask

	// open bucket bytes show up only after the closing tick
	task automatic test_open_bucket_hidden();
		send_item(1'b0, 31'd1000);
		send_item(1'b1, '0);
		sender_rest();
	endtask

	// open bucket clips at all ones, and the closed total clips the rate
	task automatic test_saturation();
		send_item(1'b0, {BYTES_W{1'b1}});
		send_item(1'b0, {BYTES_W{1'b1}});
		send_item(1'b0, {BYTES_W{1'b1}});
		send_item(1'b1, {BYTES_W{1'b1}});
		sender_rest();
	endtask

	// zero-byte ticks age the earlier buckets out of the window
	task automatic test_aging();
		for (int i = 0; i < NUM_BUCKETS; i++)
			send_item(1'b1, '0);
		sender_rest();
	endtask

	task automatic test_random_traffic();
		load_profile_t profile;
		int            run_len;
		logic          tick;
		logic [BYTES_W-1:0] nbytes;
		while (items_sent < RANDOM_ITEMS) begin
			profile       = load_profile_t'($urandom_range(0, 3));
			rx_mode       = rx_mode_t'($urandom_range(0, 3));
			sender_bursty = ($urandom_range(0, 3) != 0);
			run_len       = $urandom_range(10, 60);
			repeat (run_len) begin
				case (profile)
					LOAD_HEAVY: begin
						tick   = ($urandom_range(0, 7) == 0);
						nbytes = BYTES_W'($urandom_range(32'h7FFF_FFFF, 32'h0400_0000));
					end
					LOAD_LIGHT: begin
						tick   = ($urandom_range(0, 3) == 0);
						nbytes = BYTES_W'($urandom_range(0, 65535));
					end
					LOAD_AGING: begin
						tick   = ($urandom_range(0, 3) != 0);
						nbytes = BYTES_W'(($urandom_range(0, 3) == 0)
							? $urandom_range(0, 1000) : 0);
					end
					default: begin
						tick   = 1'($urandom_range(0, 1));
						nbytes = BYTES_W'($urandom);
					end
				endcase
				send_item(tick, nbytes);
			end
		end
		sender_rest();
	endtask

	// receiver holds off while the sender keeps offering back to back
	task automatic test_backpressure();
		sender_bursty = 1'b0;
		rx_mode       = RX_ALWAYS;
		stall_req     = 80;
		repeat (40)
			send_item(1'($urandom_range(0, 1)), BYTES_W'($urandom));
		sender_rest();
	endtask

	initial begin
		int drain_cycles;
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = '0;
		m_axis_tready = 1'b0;
		mismatches    = 0;
		items_sent    = 0;
		sender_bursty = 1'b1;
		burst_left    = 0;
		rx_mode       = RX_RANDOM;
		stall_req     = 0;
		stall_left    = 0;
		pattern_phase = 0;
		clear_window_model();
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_empty_window();
		test_open_bucket_hidden();
		test_saturation();
		test_aging();
		test_backpressure();
		test_random_traffic();
		test_backpressure();

		rx_mode = RX_ALWAYS;
		drain_cycles = 0;
		while (expected_rates.size() > 0 && drain_cycles < 20000) begin
			@(posedge clk);
			drain_cycles++;
		end
		if (expected_rates.size() > 0)
			report_mismatch("results still pending", 64'(expected_rates.size()), '0);
		repeat (4 * PIPE_LATENCY) @(posedge clk);

		if (mismatches == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

`default_nettype wire
